FILE: sv/sbpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbpg_pkg;

  // point count register
  localparam int unsigned PC_WIDTH = 7;
  localparam logic [PC_WIDTH-1:0] PC_RESET = 7'd8;

  // reported point index width
  localparam int unsigned INDEX_WIDTH = 6;

  // number of fraction bits in every coordinate
  localparam int unsigned FRAC_BITS = 12;

endpackage : sbpg_pkg

`default_nettype wire

FILE: sv/sbpg_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// one coordinate of a bisection point:
// floor((start * 2^lvl + (end - start) * knum) / 2^lvl)
module sbpg_blend #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned LVL_W       = 3,
  parameter int unsigned KNUM_W      = 7
) (
  input  wire logic signed [COORD_WIDTH-1:0] seg_start,
  input  wire logic signed [COORD_WIDTH-1:0] seg_end,
  input  wire logic        [LVL_W-1:0]       lvl,
  input  wire logic        [KNUM_W-1:0]      knum,
  output logic signed      [COORD_WIDTH-1:0] point
);

  localparam int unsigned NUM_W = COORD_WIDTH + KNUM_W + 2;

  logic signed [COORD_WIDTH:0] diff;
  logic signed [KNUM_W:0]      k_s;
  logic signed [NUM_W-1:0]     diff_ext;
  logic signed [NUM_W-1:0]     k_ext;
  logic signed [NUM_W-1:0]     prod;
  logic signed [NUM_W-1:0]     base;
  logic signed [NUM_W-1:0]     num;
  logic signed [NUM_W-1:0]     shifted;

  always_comb begin
    diff     = $signed({seg_end[COORD_WIDTH-1], seg_end})
             - $signed({seg_start[COORD_WIDTH-1], seg_start});
    k_s      = $signed({1'b0, knum});
    diff_ext = NUM_W'(diff);
    k_ext    = NUM_W'(k_s);
    prod     = diff_ext * k_ext;
    base     = NUM_W'(seg_start) <<< lvl;
    num      = base + prod;
    // arithmetic shift floors toward minus infinity
    shifted  = num >>> lvl;
    point    = shifted[COORD_WIDTH-1:0];
  end

endmodule : sbpg_blend

`default_nettype wire

FILE: sv/segment_bisection_point_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// -------   ---------  -------------------  ----------------------------------------
// in        sink       in_valid / in_ready  start_x/y/z, end_x/y/z
// out       source     out_valid/out_ready  point_x/y/z, point_index, last_point
// cfg       sink       cfg_we               cfg_wdata (point_count)
//
// one point per cycle while out_ready is high: a segment occupies the point generator
// for point_count points (saturated to MAX_POINTS), so the segment register and its
// index counter set the rate; a zero-count segment emits nothing
// a new segment is taken in the same cycle its last point moves to the output
// register, so consecutive segments stream with no gap
// rst is synchronous: clears valid flags and loads point_count with 8
// when out_ready is low the output register holds and the generator stalls
module segment_bisection_point_generator_top
  import sbpg_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          cfg_we,
  input  wire logic [PC_WIDTH-1:0]           cfg_wdata,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] start_x,
  input  wire logic signed [COORD_WIDTH-1:0] start_y,
  input  wire logic signed [COORD_WIDTH-1:0] start_z,
  input  wire logic signed [COORD_WIDTH-1:0] end_x,
  input  wire logic signed [COORD_WIDTH-1:0] end_y,
  input  wire logic signed [COORD_WIDTH-1:0] end_z,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      point_x,
  output logic signed [COORD_WIDTH-1:0]      point_y,
  output logic signed [COORD_WIDTH-1:0]      point_z,
  output logic [INDEX_WIDTH-1:0]             point_index,
  output logic                               last_point
);

  // count holds 0..MAX_POINTS, also the bit length of the largest position
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned LVL_MAX = CNT_W;
  localparam int unsigned LVL_W  = $clog2(LVL_MAX + 1);
  localparam int unsigned KNUM_W = LVL_MAX;

  // configuration register
  logic [PC_WIDTH-1:0] point_count;

  // segment register and point sequencer
  logic                          active;
  logic [IDX_W-1:0]              idx;
  logic [LVL_W-1:0]              lvl;
  logic [KNUM_W-1:0]             knum;
  logic signed [COORD_WIDTH-1:0] s_x, s_y, s_z;
  logic signed [COORD_WIDTH-1:0] e_x, e_y, e_z;

  logic                          advance;
  logic                          in_xfer;
  logic [CNT_W-1:0]              n_eff;
  logic                          is_last;
  logic [KNUM_W:0]               lvl_pow;
  logic                          lvl_wrap;
  logic signed [COORD_WIDTH-1:0] gen_x, gen_y, gen_z;

  // count saturates at MAX_POINTS; it is to be changed only while idle, which the block itself does not enforce
  always_comb begin
    if (32'(point_count) > 32'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = CNT_W'(point_count);
    end
  end

  assign is_last  = (CNT_W'(idx) + CNT_W'(1)) == n_eff;
  // output register free, or its point leaves this cycle
  assign advance  = !out_valid || out_ready;
  assign in_ready = !active || (advance && is_last);
  assign in_xfer  = in_valid && in_ready;

  // numerator runs over the odd values below 2^lvl, then the level steps up
  assign lvl_pow  = (KNUM_W + 1)'(1) << lvl;
  assign lvl_wrap = knum == KNUM_W'(lvl_pow - (KNUM_W + 1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_RESET;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (in_xfer) begin
      // a zero count consumes the segment without emitting a point
      active <= n_eff != '0;
    end else if (active && advance && is_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx  <= '0;
      lvl  <= LVL_W'(1);
      knum <= KNUM_W'(1);
      s_x  <= start_x;
      s_y  <= start_y;
      s_z  <= start_z;
      e_x  <= end_x;
      e_y  <= end_y;
      e_z  <= end_z;
    end else if (active && advance) begin
      idx <= idx + IDX_W'(1);
      if (lvl_wrap) begin
        lvl  <= lvl + LVL_W'(1);
        knum <= KNUM_W'(1);
      end else begin
        knum <= knum + KNUM_W'(2);
      end
    end
  end

  // one blend unit per axis
  sbpg_blend #(
    .COORD_WIDTH(COORD_WIDTH),
    .LVL_W      (LVL_W),
    .KNUM_W     (KNUM_W)
  ) u_blend_x (
    .seg_start(s_x),
    .seg_end  (e_x),
    .lvl      (lvl),
    .knum     (knum),
    .point    (gen_x)
  );

  sbpg_blend #(
    .COORD_WIDTH(COORD_WIDTH),
    .LVL_W      (LVL_W),
    .KNUM_W     (KNUM_W)
  ) u_blend_y (
    .seg_start(s_y),
    .seg_end  (e_y),
    .lvl      (lvl),
    .knum     (knum),
    .point    (gen_y)
  );

  sbpg_blend #(
    .COORD_WIDTH(COORD_WIDTH),
    .LVL_W      (LVL_W),
    .KNUM_W     (KNUM_W)
  ) u_blend_z (
    .seg_start(s_z),
    .seg_end  (e_z),
    .lvl      (lvl),
    .knum     (knum),
    .point    (gen_z)
  );

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= active;
    end
  end

  // output register: payload, loaded only with a fresh point
  always_ff @(posedge clk) begin
    if (advance && active) begin
      point_x     <= gen_x;
      point_y     <= gen_y;
      point_z     <= gen_z;
      point_index <= INDEX_WIDTH'(idx);
      last_point  <= is_last;
    end
  end

  // a segment with points is in the sequencer right after its transfer
  a_load_starts : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && n_eff != '0) |=> active)
    else $error("segment with points did not start");

  // numerator stays odd while points are generated
  a_knum_odd : assert property (@(posedge clk) disable iff (rst)
    active |-> knum[0])
    else $error("bisection numerator is even");

  // a pending non-final point means the segment still has points to go
  a_more_points : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_point) |-> active)
    else $error("segment ended before its last point");

endmodule : segment_bisection_point_generator_top

`default_nettype wire

FILE: test/bisection_point_checker.sv
`timescale 1ns / 1ps

module bisection_point_checker
  import sbpg_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [PC_WIDTH-1:0]           cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] end_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic [INDEX_WIDTH-1:0]        point_index,
  input  logic                          last_point,
  output int unsigned                   points_owed,
  output int unsigned                   mismatches
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t                 x;
    coord_t                 y;
    coord_t                 z;
    logic [INDEX_WIDTH-1:0] index;
    logic                   last;
  } point_t;

  point_t              owed_points[$];
  logic [PC_WIDTH-1:0] point_count;

  // floor((p0*(2^level - odd) + p1*odd) / 2^level)
  function automatic coord_t bisect(coord_t p0, coord_t p1, int level, int odd);
    longint num;
    num = longint'(p0) * ((longint'(1) << level) - odd) + longint'(p1) * odd;
    return coord_t'(num >>> level);
  endfunction

  function automatic void queue_segment_points(coord_t sx, sy, sz, ex, ey, ez);
    int     total;
    int     level;
    int     odd;
    point_t p;
    total = (point_count > MAX_POINTS) ? int'(MAX_POINTS) : int'(point_count);
    for (int i = 0; i < total; i++) begin
      level = 0;
      while ((1 << level) <= i + 1) level++;
      odd = 2 * (i + 1 - (1 << (level - 1))) + 1;
      p.x = bisect(sx, ex, level, odd);
      p.y = bisect(sy, ey, level, odd);
      p.z = bisect(sz, ez, level, odd);
      p.index = INDEX_WIDTH'(i);
      p.last = (i == total - 1);
      owed_points = {owed_points, p};
    end
  endfunction

  function automatic int field_differs(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    int     errs;
    point_t want;
    errs = 0;
    if (rst) begin
      owed_points.delete();
      point_count <= PC_RESET;
      points_owed <= 0;
      mismatches <= 0;
    end else begin
      if (cfg_we) point_count <= cfg_wdata;
      // results of a segment taken at this edge cannot leave yet, so check first
      if (out_valid && out_ready) begin
        if (owed_points.size() == 0) begin
          $display("%0t: unexpected point, expected none, actual x=%0d y=%0d z=%0d",
                   $time, point_x, point_y, point_z);
          $display("%0t: unexpected point, actual index=%0d last=%0d",
                   $time, point_index, last_point);
          errs++;
        end else begin
          want = owed_points.pop_front();
          errs += field_differs("point_x", $signed(want.x), point_x);
          errs += field_differs("point_y", $signed(want.y), point_y);
          errs += field_differs("point_z", $signed(want.z), point_z);
          errs += field_differs("point_index", want.index, point_index);
          errs += field_differs("last_point", want.last, last_point);
        end
      end
      if (in_valid && in_ready)
        queue_segment_points(start_x, start_y, start_z, end_x, end_y, end_z);
      points_owed <= owed_points.size();
      mismatches <= mismatches + errs;
    end
  end

endmodule

FILE: test/tb_segment_bisection_point_generator_top.sv
`timescale 1ns / 1ps

module tb_segment_bisection_point_generator_top;
  import sbpg_pkg::*;

  localparam int unsigned MAX_POINTS  = 64;
  localparam int unsigned COORD_WIDTH = 16;

  // random segments after the directed ones
  localparam int RANDOM_ITEMS = 185;
  // receiver hold-off long enough to back the block up into its input
  localparam int LONG_HOLD = 300;
  // idle cycles after the last point: a zero-count segment emits no point to wait for
  localparam int DRAIN_CYCLES = 4;
  // worst case: ~230 segments x 64 points, each behind stalls and gaps, taken ~4x over
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  logic clk = 1'b0;
  logic rst;

  logic                cfg_we;
  logic [PC_WIDTH-1:0] cfg_wdata;

  logic   in_valid;
  logic   in_ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;

  logic                   out_valid;
  logic                   out_ready;
  coord_t                 point_x;
  coord_t                 point_y;
  coord_t                 point_z;
  logic [INDEX_WIDTH-1:0] point_index;
  logic                   last_point;

  // from the checker
  int unsigned points_owed;
  int unsigned mismatches;

  // asks the receiver for its one long hold-off
  logic hold_request;

  int unsigned cycle_count;

  // sender gaps are skipped while this is set
  bit steady;

  segment_bisection_point_generator_top #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) dut (.*);

  bisection_point_checker #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) points_chk (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit in case a transfer never happens
  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // full range mostly, with the extremes and values near zero mixed in
  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return coord_t'(int'($urandom_range(0, 16)) - 8);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // one input transfer; called at a rising edge, returns at the accepting edge
  // valid stays high across back-to-back transfers so it only drops on a gap
  task automatic offer_segment(coord_t sx, sy, sz, ex, ey, ez);
    int gap;
    gap = steady ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x <= sx;
    start_y <= sy;
    start_z <= sz;
    end_x <= ex;
    end_y <= ey;
    end_z <= ez;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic offer_random_segment();
    coord_t sx, sy, sz;
    sx = random_coord();
    sy = random_coord();
    sz = random_coord();
    // a degenerate segment now and then
    if ($urandom_range(0, 7) == 0)
      offer_segment(sx, sy, sz, sx, sy, sz);
    else
      offer_segment(sx, sy, sz, random_coord(), random_coord(), random_coord());
  endtask

  // sender pauses until every owed point has left and the block has settled
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    // the owed count is a registered copy of the checker's queue size
    @(posedge clk);
    while (points_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register writes only while the block is idle
  task automatic write_point_count(int count);
    wait_for_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= PC_WIDTH'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random ready gaps, runs of steady ready, one long hold-off
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        // block fills up while the sender keeps offering
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 15) == 0) begin
        // stretch with no stalls at all
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end else begin
        gap = idle_cycles();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int random_sent;
    int count;
    int pick;
    int phase_items;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    start_x <= '0;
    start_y <= '0;
    start_z <= '0;
    end_x <= '0;
    end_y <= '0;
    end_z <= '0;
    hold_request <= 1'b0;
    steady = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset count of eight: extremes, patterns, small negatives for flooring
    offer_segment('0, '0, '0, '0, '0, '0);
    offer_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    offer_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
    offer_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);
    offer_segment(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    offer_segment(1, -1, 4096, -1, 1, -4096);
    offer_segment(-3, 7, -4095, 2, -8, 4097);

    // zero count emits nothing
    write_point_count(0);
    offer_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    offer_segment(COORD_MAX, 0, COORD_MIN, COORD_MIN, 0, COORD_MAX);
    offer_segment(1, 2, 3, 4, 5, 6);

    // full count, deepest bisection level
    write_point_count(MAX_POINTS);
    offer_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    offer_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
    offer_segment(-1, 16'h5555, COORD_MIN, 1, 16'hAAAA, -1);

    // counts above the limit saturate
    write_point_count(MAX_POINTS + 1);
    offer_segment(COORD_MAX, -7, COORD_MIN, COORD_MIN, 7, COORD_MAX);
    write_point_count((1 << PC_WIDTH) - 1);
    offer_segment(COORD_MIN, COORD_MAX, 0, COORD_MAX, COORD_MIN, -1);
    offer_segment(5, -5, 5, -5, 5, -5);

    // single point, every segment is its own last point
    write_point_count(1);
    offer_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    offer_segment(COORD_MAX, COORD_MIN, -1, COORD_MIN, COORD_MAX, 0);
    offer_segment(-1, -1, -1, 0, 0, 0);

    write_point_count(2);
    offer_segment(-1, 0, COORD_MIN, 0, -1, COORD_MAX);
    offer_segment(COORD_MAX, COORD_MIN, 3, COORD_MAX, COORD_MIN, -3);

    // first random phase streams with no gaps while the receiver holds off
    write_point_count(4);
    steady = 1'b1;
    hold_request <= 1'b1;
    repeat (24) offer_random_segment();
    random_sent = 24;

    // then phases of random counts, mostly small
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        count = 0;
      else if (pick == 1)
        count = $urandom_range(MAX_POINTS, (1 << PC_WIDTH) - 1);
      else if (pick < 4)
        count = $urandom_range(13, MAX_POINTS - 1);
      else
        count = $urandom_range(1, 12);
      phase_items = (count > 12) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      write_point_count(count);
      steady = ($urandom_range(0, 3) == 0);
      repeat (phase_items) offer_random_segment();
      random_sent += phase_items;
    end

    // all points back, then a few quiet cycles for stray transfers
    wait_for_drain();
    if (mismatches == 0 && points_owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/sbpg_pkg.sv
sv/sbpg_blend.sv
sv/segment_bisection_point_generator_top.sv
test/bisection_point_checker.sv
test/tb_segment_bisection_point_generator_top.sv
